// ----- hw/rtl/mlcd_pkg.sv -----
// ----------------------------------------------------------------------------
// mlcd_pkg
// Shared types and constants of the memory LCD frame serializer.
// ----------------------------------------------------------------------------
package mlcd_pkg;

  // command byte bits
  localparam logic [7:0] CmdWrite = 8'h01;
  localparam logic [7:0] CmdVcom  = 8'h02;
  localparam logic [7:0] CmdClear = 8'h04;

  // operation codes
  localparam logic OpPixel = 1'b0;
  localparam logic OpClear = 1'b1;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegBytesPerLine = 1'd0;
  localparam logic [CfgIdxW-1:0] RegLinesPerFrame = 1'd1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [6:0] BytesPerLineReset = 7'd12;
  localparam logic [7:0] LinesPerFrameReset = 8'd96;

  localparam int unsigned DefMaxLineBytes = 64;
  localparam int unsigned DefMaxLines = 255;

  // one job: up to five bytes sent in a row for one item
  localparam int unsigned JobBytes = 5;
  localparam int unsigned JobCntW = 3;
  localparam int unsigned JobDepth = 2;

  typedef struct packed {
    logic [JobBytes-1:0][7:0] bytes;  // bytes[0] goes out first
    logic [JobCntW-1:0]       count;  // 1 to JobBytes
    logic                     ends;   // transfer ends after the last byte
  } job_t;

endpackage

// ----- hw/rtl/mlcd_front.sv -----
// ----------------------------------------------------------------------------
// mlcd_front
// Holds configuration and frame state, turns each item into a byte job.
// ----------------------------------------------------------------------------
module mlcd_front #(
  parameter int unsigned MAX_LINE_BYTES = mlcd_pkg::DefMaxLineBytes,
  parameter int unsigned MAX_LINES      = mlcd_pkg::DefMaxLines
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mlcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mlcd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          accept_i,
  input  logic                          operation_i,
  input  logic [7:0]                    pixel_byte_i,
  output logic                          job_push_o,
  output mlcd_pkg::job_t                job_o
);
  import mlcd_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_LINE_BYTES + 1);
  localparam int unsigned EffW = (CntW > 7) ? CntW : 7;

  logic [6:0]      bpl_q;
  logic [7:0]      lpf_q;
  logic            vcom_q, vcom_d;
  logic            in_frame_q, in_frame_d;
  logic [CntW-1:0] bil_q, bil_d;
  logic [7:0]      line_q, line_d;

  logic [EffW-1:0] eff_bytes, bil_inc;
  logic [7:0]      eff_lines, line_cur, last_byte;
  logic            eol, frame_done;
  logic [7:0]      cmd;

  always_comb begin
    if (bpl_q == 7'd0) begin
      eff_bytes = EffW'(1);
    end else if (EffW'(bpl_q) > EffW'(MAX_LINE_BYTES)) begin
      eff_bytes = EffW'(MAX_LINE_BYTES);
    end else begin
      eff_bytes = EffW'(bpl_q);
    end
    if (lpf_q == 8'd0) begin
      eff_lines = 8'd1;
    end else if (lpf_q > 8'(MAX_LINES)) begin
      eff_lines = 8'(MAX_LINES);
    end else begin
      eff_lines = lpf_q;
    end
  end

  always_comb begin
    bil_inc    = in_frame_q ? (EffW'(bil_q) + EffW'(1)) : EffW'(1);
    line_cur   = in_frame_q ? line_q : 8'd1;
    eol        = (bil_inc >= eff_bytes);
    frame_done = eol && !(line_cur < eff_lines);
    last_byte  = frame_done ? 8'h00 : (line_cur + 8'd1);
    cmd        = (vcom_q ? CmdVcom : 8'h00);

    vcom_d     = vcom_q;
    in_frame_d = in_frame_q;
    bil_d      = bil_q;
    line_d     = line_q;
    job_push_o = 1'b0;
    job_o      = '0;

    if (accept_i) begin
      if (operation_i == OpClear) begin
        // a clear inside a frame is dropped
        if (!in_frame_q) begin
          job_push_o     = 1'b1;
          job_o.bytes[0] = cmd | CmdClear;
          job_o.bytes[1] = 8'h00;
          job_o.count    = JobCntW'(2);
          job_o.ends     = 1'b1;
          vcom_d         = ~vcom_q;
        end
      end else begin
        job_push_o = 1'b1;
        if (!in_frame_q) begin
          vcom_d         = ~vcom_q;
          job_o.bytes[0] = cmd | CmdWrite;
          job_o.bytes[1] = 8'h01;
          job_o.bytes[2] = pixel_byte_i;
          job_o.bytes[3] = 8'h00;
          job_o.bytes[4] = last_byte;
          job_o.count    = eol ? JobCntW'(5) : JobCntW'(3);
        end else begin
          job_o.bytes[0] = pixel_byte_i;
          job_o.bytes[1] = 8'h00;
          job_o.bytes[2] = last_byte;
          job_o.count    = eol ? JobCntW'(3) : JobCntW'(1);
        end
        job_o.ends = frame_done;
        if (frame_done) begin
          in_frame_d = 1'b0;
          bil_d      = '0;
          line_d     = 8'd1;
        end else begin
          in_frame_d = 1'b1;
          bil_d      = eol ? '0 : CntW'(bil_inc);
          line_d     = eol ? last_byte : line_cur;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpl_q      <= BytesPerLineReset;
      lpf_q      <= LinesPerFrameReset;
      vcom_q     <= 1'b0;
      in_frame_q <= 1'b0;
      bil_q      <= '0;
      line_q     <= 8'd1;
    end else begin
      if (cfg_we_i && cfg_idx_i == RegBytesPerLine) begin
        bpl_q <= cfg_data_i[6:0];
      end
      if (cfg_we_i && cfg_idx_i == RegLinesPerFrame) begin
        lpf_q <= cfg_data_i[7:0];
      end
      vcom_q     <= vcom_d;
      in_frame_q <= in_frame_d;
      bil_q      <= bil_d;
      line_q     <= line_d;
    end
  end

  // between frames the counters sit at their start values
  a_idle_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (line_q == 8'd1 && bil_q == '0))
    else $error("frame counters not at start between frames");

  // a clear inside a frame never produces a job
  a_clear_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && operation_i == OpClear && in_frame_q) |-> !job_push_o)
    else $error("clear inside frame produced a job");

endmodule

// ----- hw/rtl/mlcd_job_fifo.sv -----
// ----------------------------------------------------------------------------
// mlcd_job_fifo
// Short queue of byte jobs between the front and the bit serializer.
// ----------------------------------------------------------------------------
module mlcd_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mlcd_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output mlcd_pkg::job_t data_o
);
  import mlcd_pkg::*;

  localparam int unsigned PtrW = (JobDepth > 1) ? $clog2(JobDepth) : 1;
  localparam int unsigned CntW = $clog2(JobDepth + 1);

  job_t            mem_q [JobDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(JobDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(JobDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(JobDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("job pushed into full queue");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(JobDepth))
    else $error("job queue count out of range");

endmodule

// ----- hw/rtl/mlcd_back.sv -----
// ----------------------------------------------------------------------------
// mlcd_back
// Shifts job bytes out LSB first into a one-bit output register.
// ----------------------------------------------------------------------------
module mlcd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_empty_i,
  input  mlcd_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           empty,
  input  logic           pop,
  output logic           serial_bit_o,
  output logic           transfer_end_o,
  output logic           last_of_item_o
);
  import mlcd_pkg::*;

  job_t               cur_q;
  logic               active_q;
  logic [JobCntW-1:0] byte_idx_q;
  logic [2:0]         bit_idx_q;
  logic               ov_q, obit_q, oend_q, olast_q;

  logic               advance, last_bit, need_job;
  logic [7:0]         cur_byte;

  assign advance   = !ov_q || pop;
  assign cur_byte  = cur_q.bytes[byte_idx_q];
  assign last_bit  = (bit_idx_q == 3'd7) && (byte_idx_q == cur_q.count - JobCntW'(1));
  // reload while the last bit of a job goes out, so jobs run without gaps
  assign need_job  = advance && (!active_q || last_bit);
  assign job_pop_o = need_job && !job_empty_i;

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      cur_q <= job_i;
    end
    if (advance && active_q) begin
      obit_q  <= cur_byte[bit_idx_q];
      oend_q  <= last_bit && cur_q.ends;
      olast_q <= last_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      byte_idx_q <= '0;
      bit_idx_q  <= '0;
      ov_q       <= 1'b0;
    end else if (advance) begin
      ov_q <= active_q;
      if (need_job) begin
        active_q   <= !job_empty_i;
        byte_idx_q <= '0;
        bit_idx_q  <= '0;
      end else begin
        bit_idx_q <= bit_idx_q + 3'd1;
        if (bit_idx_q == 3'd7) begin
          byte_idx_q <= byte_idx_q + JobCntW'(1);
        end
      end
    end
  end

  assign empty          = !ov_q;
  assign serial_bit_o   = obit_q;
  assign transfer_end_o = oend_q;
  assign last_of_item_o = olast_q;

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && oend_q) |-> olast_q)
    else $error("transfer end not on last bit of item");

  a_byte_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (byte_idx_q < cur_q.count))
    else $error("byte index past job length");

endmodule

// ----- hw/rtl/memory_lcd_frame_serializer.sv -----
// ----------------------------------------------------------------------------
// memory_lcd_frame_serializer
// Memory LCD line writer: pixel bytes or clear requests in, LSB-first
// serial data bits out, with command, line address and trailer bytes.
//
//   channel  handshake         payload
//   -------  ----------------  ---------------------------------------------
//   input    push / full       operation_i, pixel_byte_i
//   result   empty / pop       serial_bit_o, transfer_end_o, last_of_item_o
//   config   cfg_we_i          cfg_idx_i, cfg_data_i
//
// One result bit per cycle from the output register while pop is high and
// jobs wait; a pixel byte gives 8 bits, 24 or 40 when a command, trailer
// or line address comes with it. The bit shifter in the back end sets that
// rate; the front takes one item per cycle while the two-entry job queue
// has room (full follows the queue). A dropped clear makes no job. Reset
// clears all control state and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module memory_lcd_frame_serializer #(
  parameter int unsigned MAX_LINE_BYTES = mlcd_pkg::DefMaxLineBytes,
  parameter int unsigned MAX_LINES      = mlcd_pkg::DefMaxLines
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mlcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mlcd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic                          operation_i,
  input  logic [7:0]                    pixel_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          serial_bit_o,
  output logic                          transfer_end_o,
  output logic                          last_of_item_o
);
  import mlcd_pkg::*;

  logic accept;
  logic job_push, job_pop, job_empty, job_full;
  job_t job_in, job_out;

  assign full   = job_full;
  assign accept = push && !job_full;

  mlcd_front #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES),
    .MAX_LINES      (MAX_LINES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .operation_i  (operation_i),
    .pixel_byte_i (pixel_byte_i),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  mlcd_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_out)
  );

  mlcd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_empty_i    (job_empty),
    .job_i          (job_out),
    .job_pop_o      (job_pop),
    .empty          (empty),
    .pop            (pop),
    .serial_bit_o   (serial_bit_o),
    .transfer_end_o (transfer_end_o),
    .last_of_item_o (last_of_item_o)
  );

endmodule
